FILE: rtl/qtba_pkg.sv
// Shared types and request codes for the Q-table best-action block.
`default_nettype none
package qtba_pkg;

  localparam int unsigned MODE_W  = 2;
  localparam int unsigned ROW_W   = 10;
  localparam int unsigned COL_W   = 3;
  localparam int unsigned QVAL_W  = 32;
  localparam int unsigned CIU_W   = 4;

  typedef logic [MODE_W-1:0] mode_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [QVAL_W-1:0] qval_t;
  typedef logic [CIU_W-1:0]  ciu_t;

  localparam mode_t MODE_WRITE = 2'd0;
  localparam mode_t MODE_READ  = 2'd1;
  localparam mode_t MODE_BEST  = 2'd2;
  localparam mode_t MODE_NONE  = 2'd3;

endpackage : qtba_pkg
`default_nettype wire

FILE: rtl/qtba_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none
module qtba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule : qtba_ram
`default_nettype wire

FILE: rtl/q_table_best_action_top.sv
// Top level of the Q-table best-action block: sequencer, comparator and table RAM.
//
// Q-value table of ROWS states by COLS actions, signed Q16.16 entries, held in
// one single-port RAM. After reset the block runs a clearing pass that writes
// zero to every one of the 2**(clog2(ROWS)+clog2(COLS)) RAM words (8192 with the
// defaults); busy is high throughout and no request is taken, while
// configuration writes are accepted at any time. A request is taken when start
// is high and busy is low. A write or an out-of-range read is answered from
// the execute state, an in-range read passes through the read-wait state, and
// a best query reads column 0 in the execute state, then the other columns;
// the single RAM port delivers one entry per cycle and one signed comparator
// folds each into the running maximum. busy is high from accept until the
// cycle that carries out_valid, so the next request may start in that cycle.
// Each result is shown for exactly one cycle with out_valid high; the
// receiver cannot stall it. cfg_ready is always high.
`default_nettype none
module q_table_best_action_top #(
  parameter int unsigned ROWS = 1024,
  parameter int unsigned COLS = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // request transaction
  input  wire logic                 start,
  output logic                      busy,
  input  wire qtba_pkg::mode_t      in_mode,
  input  wire qtba_pkg::row_t       in_row,
  input  wire qtba_pkg::col_t       in_column,
  input  wire qtba_pkg::qval_t      in_value,
  input  wire logic                 in_exclude_last,
  // result transaction
  output logic                      out_valid,
  output qtba_pkg::qval_t           out_read_value,
  output qtba_pkg::col_t            out_best_column,
  output qtba_pkg::qval_t           out_best_value,
  output logic                      out_out_of_range,
  // configuration transaction
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire qtba_pkg::ciu_t       cfg_columns_in_use
);

  import qtba_pkg::*;

  // RAM word address = {row, column}; columns padded up to a power of two
  localparam int unsigned RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned CW    = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int unsigned AW    = RW + CW;
  localparam int unsigned DEPTH = 1 << AW;
  localparam logic [16:0] ROWS_L = 17'(ROWS);
  localparam logic [6:0]  COLS_L = 7'(COLS);

  // sequencer states
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_EXEC  = 3'd2;
  localparam logic [2:0] ST_RWAIT = 3'd3;
  localparam logic [2:0] ST_SCAN  = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] clr_addr_r;
  ciu_t          ciu_r;

  // latched request
  mode_t         mode_r;
  logic [RW-1:0] row_idx_r;
  col_t          col_r;
  qval_t         value_r;
  logic          row_ok_r;
  logic          col_ok_r;
  ciu_t          until_r;

  // scan state
  ciu_t          iss_r, iss_nxt;
  logic          dv_r, dv_nxt;
  ciu_t          cmp_col_r, cmp_col_nxt;
  qval_t         best_val_r;
  ciu_t          best_col_r;

  // result register
  logic          out_valid_r;
  qval_t         out_read_value_r;
  col_t          out_best_column_r;
  qval_t         out_best_value_r;
  logic          out_oor_r;

  // RAM port
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  qval_t         ram_wdata;
  qval_t         ram_rdata;

  // effective column count: 0 counts as 1, anything above COLS as COLS
  ciu_t          width;
  logic          accept;
  logic [15:0]   row_ext;
  logic [6:0]    col_ext;
  logic [6:0]    iss_ext;
  logic          issuing;
  qval_t         nbest_val;
  ciu_t          nbest_col;
  logic          res_fire;
  qval_t         res_read_value;
  col_t          res_best_column;
  qval_t         res_best_value;
  logic          res_oor;

  always_comb begin
    if (ciu_r == '0) begin
      width = ciu_t'(1);
    end else if ({3'b000, ciu_r} > COLS_L) begin
      width = ciu_t'(COLS_L);
    end else begin
      width = ciu_r;
    end
  end

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  assign row_ext = 16'(in_row);
  assign col_ext = 7'(col_r);
  assign iss_ext = 7'(iss_r);
  assign issuing = (state_r == ST_SCAN) && (iss_r < until_r);

  // shared signed comparator folding one RAM word per cycle
  always_comb begin
    nbest_val = best_val_r;
    nbest_col = best_col_r;
    if (dv_r) begin
      if (cmp_col_r == '0) begin
        nbest_val = ram_rdata;
        nbest_col = '0;
      end else if ($signed(ram_rdata) > $signed(best_val_r)) begin
        nbest_val = ram_rdata;
        nbest_col = cmp_col_r;
      end
    end
  end

  // RAM port and sequencer
  always_comb begin
    state_nxt       = state_r;
    ram_we          = 1'b0;
    ram_addr        = {row_idx_r, col_ext[CW-1:0]};
    ram_wdata       = value_r;
    iss_nxt         = iss_r;
    dv_nxt          = 1'b0;
    cmp_col_nxt     = cmp_col_r;
    res_fire        = 1'b0;
    res_read_value  = '0;
    res_best_column = '0;
    res_best_value  = '0;
    res_oor         = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_addr_r;
        ram_wdata = '0;
        if (clr_addr_r == {AW{1'b1}}) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (mode_r)
          MODE_WRITE: begin
            ram_we    = row_ok_r && col_ok_r;
            res_fire  = 1'b1;
            res_oor   = !col_ok_r;
            state_nxt = ST_IDLE;
          end
          MODE_READ: begin
            if (row_ok_r && col_ok_r) begin
              state_nxt = ST_RWAIT;
            end else begin
              res_fire  = 1'b1;
              res_oor   = !col_ok_r;
              state_nxt = ST_IDLE;
            end
          end
          MODE_BEST: begin
            if (row_ok_r) begin
              // column 0 is always read first
              ram_addr    = {row_idx_r, {CW{1'b0}}};
              dv_nxt      = 1'b1;
              cmp_col_nxt = '0;
              iss_nxt     = ciu_t'(1);
              state_nxt   = ST_SCAN;
            end else begin
              res_fire  = 1'b1;
              state_nxt = ST_IDLE;
            end
          end
          default: begin
            res_fire  = 1'b1;
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_RWAIT: begin
        res_fire       = 1'b1;
        res_read_value = ram_rdata;
        state_nxt      = ST_IDLE;
      end
      ST_SCAN: begin
        if (issuing) begin
          ram_addr    = {row_idx_r, iss_ext[CW-1:0]};
          dv_nxt      = 1'b1;
          cmp_col_nxt = iss_r;
          iss_nxt     = iss_r + ciu_t'(1);
        end else begin
          // last word folded this cycle
          res_fire        = 1'b1;
          res_best_column = nbest_col[COL_W-1:0];
          res_best_value  = nbest_val;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      ciu_r       <= ciu_t'(8);
      out_valid_r <= 1'b0;
      dv_r        <= 1'b0;
      iss_r       <= '0;
      cmp_col_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= res_fire;
      dv_r        <= dv_nxt;
      iss_r       <= iss_nxt;
      cmp_col_r   <= cmp_col_nxt;
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (cfg_valid && cfg_ready) begin
        ciu_r <= cfg_columns_in_use;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r    <= in_mode;
      row_idx_r <= row_ext[RW-1:0];
      col_r     <= in_column;
      value_r   <= in_value;
      row_ok_r  <= ({7'b0, in_row} < ROWS_L);
      col_ok_r  <= ({1'b0, in_column} < width);
      until_r   <= width - ciu_t'(in_exclude_last);
    end
    if (dv_r) begin
      best_val_r <= nbest_val;
      best_col_r <= nbest_col;
    end
    if (res_fire) begin
      out_read_value_r  <= res_read_value;
      out_best_column_r <= res_best_column;
      out_best_value_r  <= res_best_value;
      out_oor_r         <= res_oor;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_value   = out_read_value_r;
  assign out_best_column  = out_best_column_r;
  assign out_best_value   = out_best_value_r;
  assign out_out_of_range = out_oor_r;

  qtba_ram #(
    .WIDTH (QVAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // a result only follows a cycle of work
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without preceding work");

  // the table is never written while waiting for a request
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !ram_we)
    else $error("RAM write while idle");

  // scan never issues past the columns in use
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (iss_r <= until_r) || (until_r == '0))
    else $error("scan counter beyond scan limit");

  // a compare slot always follows an issued read
  a_dv_follows_issue: assert property (@(posedge clk) disable iff (!rst_n)
    dv_r |-> ($past(state_r) == ST_EXEC) || ($past(state_r) == ST_SCAN))
    else $error("compare data without a read");

endmodule : q_table_best_action_top
`default_nettype wire

FILE: dv/tb.sv
// Testbench for q_table_best_action_top: scoreboard prediction of Q-table writes, reads and best queries.
`timescale 1ns / 100ps

module tb;
  import qtba_pkg::*;

  localparam int unsigned ROWS = 1024;
  localparam int unsigned COLS = 8;
  // clearing pass plus the worst-case idle gap and latency of every request, with wide margin
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned MAX_REPORTS = 10;

  // One result transaction, field order matches the out_ ports.
  typedef struct packed {
    qval_t read_value;
    col_t  best_column;
    qval_t best_value;
    logic  out_of_range;
  } q_result_t;

  // Scoreboard: keeps its own copy of the Q-table and the column setting,
  // predicts each accepted request and checks results in order.
  class best_action_tracker;
    qval_t     q_entries [0:ROWS*COLS-1];
    ciu_t      columns_cfg;
    q_result_t pending_results[$];
    int        failures;

    function new();
      foreach (q_entries[i]) q_entries[i] = '0;
      columns_cfg = ciu_t'(8);
      failures = 0;
    endfunction

    function void set_columns(ciu_t v);
      columns_cfg = v;
    endfunction

    function int pending_count();
      return pending_results.size();
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= MAX_REPORTS) $display("%s", msg);
    endfunction

    function void note_request(mode_t mode, row_t row, col_t column, qval_t value, logic excl);
      q_result_t   r;
      int unsigned w;
      int unsigned base;
      int          span;
      r = '0;
      w = columns_cfg;
      if (w < 1) w = 1;
      if (w > COLS) w = COLS;
      base = row * COLS;
      case (mode)
        MODE_WRITE, MODE_READ: begin
          r.out_of_range = (column >= w);
          if (!r.out_of_range) begin
            if (mode == MODE_WRITE) q_entries[base + column] = value;
            else r.read_value = q_entries[base + column];
          end
        end
        MODE_BEST: begin
          span = int'(w) - int'(excl);
          r.best_value = q_entries[base];
          for (int j = 1; j < span; j++) begin
            if ($signed(q_entries[base + j]) > $signed(r.best_value)) begin
              r.best_value = q_entries[base + j];
              r.best_column = col_t'(j);
            end
          end
        end
        default: ;
      endcase
      pending_results.push_back(r);
    endfunction

    function void check_result(q_result_t got);
      q_result_t want;
      if (pending_results.size() == 0) begin
        flag($sformatf("unexpected result: read %h col %0d best %h oor %0d",
                       got.read_value, got.best_column, got.best_value, got.out_of_range));
        return;
      end
      want = pending_results.pop_front();
      if (got.read_value !== want.read_value || got.best_column !== want.best_column ||
          got.best_value !== want.best_value || got.out_of_range !== want.out_of_range)
        flag($sformatf("result differs: exp read %h col %0d best %h oor %0d, got read %h col %0d best %h oor %0d",
                       want.read_value, want.best_column, want.best_value, want.out_of_range,
                       got.read_value, got.best_column, got.best_value, got.out_of_range));
    endfunction
  endclass

  // Clock and reset; every input starts at a known value.
  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  start = 1'b0;
  mode_t in_mode = MODE_NONE;
  row_t  in_row = '0;
  col_t  in_column = '0;
  qval_t in_value = '0;
  logic  in_exclude_last = 1'b0;
  logic  cfg_valid = 1'b0;
  ciu_t  cfg_columns_in_use = '0;

  logic  busy;
  logic  out_valid;
  qval_t out_read_value;
  col_t  out_best_column;
  qval_t out_best_value;
  logic  out_out_of_range;
  logic  cfg_ready;

  best_action_tracker tracker;
  int unsigned cycle_count = 0;

  always #1 clk = ~clk;

  q_table_best_action_top #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_mode           (in_mode),
    .in_row            (in_row),
    .in_column         (in_column),
    .in_value          (in_value),
    .in_exclude_last   (in_exclude_last),
    .out_valid         (out_valid),
    .out_read_value    (out_read_value),
    .out_best_column   (out_best_column),
    .out_best_value    (out_best_value),
    .out_out_of_range  (out_out_of_range),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_columns_in_use(cfg_columns_in_use)
  );

  // Monitor: samples every handshake at the clock edge, before the DUT's
  // nonblocking updates land. A request transaction accepted at the same edge
  // as a result strobe is queued behind the older expectation, so order holds.
  always @(posedge clk) begin
    q_result_t got;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) tracker.set_columns(cfg_columns_in_use);
      if (start && !busy)
        tracker.note_request(in_mode, in_row, in_column, in_value, in_exclude_last);
      if (out_valid) begin
        got.read_value   = out_read_value;
        got.best_column  = out_best_column;
        got.best_value   = out_best_value;
        got.out_of_range = out_out_of_range;
        tracker.check_result(got);
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("q_table_best_action_top: mismatch");
      $finish;
    end
  end

  // Present one request and hold it until accepted (start high, busy low).
  // Entered and left at a clock edge; start stays high on exit so back-to-back
  // requests need no extra assignment in the same step.
  task automatic send_request(mode_t m, row_t r, col_t c, qval_t v, logic x, bit allow_gap);
    int unsigned gap;
    if (allow_gap && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    in_mode         <= m;
    in_row          <= r;
    in_column       <= c;
    in_value        <= v;
    in_exclude_last <= x;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Wait until every outstanding result has arrived, then let the block settle.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (tracker.pending_count() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Column-count write; only issued with the block idle.
  task automatic write_columns(ciu_t v);
    drain();
    cfg_valid          <= 1'b1;
    cfg_columns_in_use <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random request: mostly a handful of hot rows so reads and best queries
  // see written data; values lean toward ties and sign extremes.
  task automatic random_request(bit allow_gap);
    mode_t       m;
    row_t        r;
    col_t        c;
    qval_t       v;
    logic        x;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40)      m = MODE_WRITE;
    else if (pick < 65) m = MODE_READ;
    else if (pick < 95) m = MODE_BEST;
    else                m = MODE_NONE;
    pick = $urandom_range(0, 9);
    if (pick == 0)      r = row_t'($urandom);
    else if (pick == 1) r = $urandom_range(0, 1) ? row_t'(ROWS - 1) : '0;
    else                r = row_t'($urandom_range(0, 7));
    c = col_t'($urandom_range(0, 7));
    case ($urandom_range(0, 5))
      0: v = qval_t'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = 32'hffff_ffff;
          default: v = '0;
        endcase
      end
      2: v = qval_t'(int'($urandom_range(0, 511)) - 256);
      default: v = qval_t'((int'($urandom_range(0, 4)) - 2) * 65536);
    endcase
    x = logic'($urandom_range(0, 1));
    send_request(m, r, c, v, x, allow_gap);
  endtask

  localparam int NUM_PHASES = 12;
  localparam int PHASE_ITEMS = 160;

  initial begin
    ciu_t phase_cols [NUM_PHASES];
    phase_cols = '{ciu_t'(8), ciu_t'(1), ciu_t'(5), ciu_t'(15), ciu_t'(2), ciu_t'(0),
                   ciu_t'(7), ciu_t'(3), ciu_t'(9), ciu_t'(4), ciu_t'(6), ciu_t'(8)};
    tracker = new();

    // Synchronous reset, once; the block then runs its clearing pass with
    // busy high, which the request handshake simply waits out.
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset column count (8).
    send_request(MODE_BEST,  row_t'(5),    col_t'(0), '0,            1'b0, 1'b1); // cleared row
    send_request(MODE_WRITE, row_t'(1023), col_t'(7), 32'h7fff_ffff, 1'b0, 1'b1);
    send_request(MODE_WRITE, row_t'(1023), col_t'(3), 32'h7fff_ffff, 1'b1, 1'b1);
    send_request(MODE_BEST,  row_t'(1023), col_t'(0), '0,            1'b0, 1'b1); // tie: lowest col
    send_request(MODE_BEST,  row_t'(1023), col_t'(0), '0,            1'b1, 1'b1); // last col dropped
    send_request(MODE_WRITE, row_t'(0),    col_t'(0), 32'h8000_0000, 1'b0, 1'b1);
    send_request(MODE_WRITE, row_t'(0),    col_t'(5), 32'hffff_ffff, 1'b0, 1'b1);
    send_request(MODE_BEST,  row_t'(0),    col_t'(7), '0,            1'b0, 1'b1); // col 0 is minimum
    send_request(MODE_READ,  row_t'(1023), col_t'(7), '0,            1'b0, 1'b1);
    send_request(MODE_READ,  row_t'(0),    col_t'(0), 32'hffff_ffff, 1'b1, 1'b1);
    send_request(MODE_NONE,  row_t'(1023), col_t'(7), 32'hffff_ffff, 1'b1, 1'b1); // unused mode
    send_request(MODE_WRITE, row_t'(2),    col_t'(7), 32'h0001_0000, 1'b0, 1'b1);
    send_request(MODE_BEST,  row_t'(2),    col_t'(0), '0,            1'b1, 1'b1);
    send_request(MODE_BEST,  row_t'(2),    col_t'(0), '0,            1'b0, 1'b1);

    // Zero columns behaves as one.
    write_columns(ciu_t'(0));
    send_request(MODE_WRITE, row_t'(3),    col_t'(1), 32'h1234_5678, 1'b0, 1'b1); // ignored, flagged
    send_request(MODE_READ,  row_t'(1023), col_t'(3), '0,            1'b0, 1'b1); // flagged, reads 0
    send_request(MODE_BEST,  row_t'(1023), col_t'(0), '0,            1'b1, 1'b1); // only col 0
    send_request(MODE_BEST,  row_t'(2),    col_t'(0), '0,            1'b0, 1'b1);

    // Above eight clamps to eight.
    write_columns(ciu_t'(15));
    send_request(MODE_READ,  row_t'(1023), col_t'(7), '0,            1'b0, 1'b1);
    send_request(MODE_BEST,  row_t'(1023), col_t'(0), '0,            1'b1, 1'b1);

    write_columns(ciu_t'(3));
    send_request(MODE_WRITE, row_t'(4),    col_t'(2), 32'h0000_0005, 1'b0, 1'b1);
    send_request(MODE_WRITE, row_t'(4),    col_t'(3), 32'h7fff_ffff, 1'b0, 1'b1); // ignored
    send_request(MODE_BEST,  row_t'(4),    col_t'(0), '0,            1'b1, 1'b1);
    send_request(MODE_BEST,  row_t'(4),    col_t'(0), '0,            1'b0, 1'b1);
    send_request(MODE_READ,  row_t'(4),    col_t'(3), '0,            1'b0, 1'b1);

    // Random part, one column setting per phase; the last phase runs
    // back-to-back with no idle cycles.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_columns(phase_cols[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) random_request(p != NUM_PHASES - 1);
    end

    // Wait for the final results, then settle.
    start <= 1'b0;
    @(posedge clk);
    while (tracker.pending_count() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.failures == 0 && tracker.pending_count() == 0) begin
      $display("q_table_best_action_top: match");
    end else begin
      $display("q_table_best_action_top: mismatch");
    end
    $finish;
  end

endmodule
